@@ sv/bf3_pkg.sv @@
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared constants and types of the 3x3 box filter stream.
// ----------------------------------------------------------------------------
package bf3_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int PIX_W     = 8;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = 11;
  localparam int CSUM_W    = 10;  // three pixels
  localparam int SUM_W     = 12;  // nine pixels
  localparam int LINE_W    = 2 * PIX_W;

  localparam logic [WID_W-1:0] WIDTH_MAX   = WID_W'(MAX_WIDTH);
  localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(MAX_WIDTH);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_LATER
  } phase_t;

  // item held in the input register
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             flush;
    logic [COL_W-1:0] col;
    logic             eor;
    phase_t           phase;
  } item_t;

  typedef struct packed {
    logic [SUM_W-1:0] box_sum;
    logic [COL_W-1:0] out_column;
    logic             end_of_row;
    logic             end_of_frame;
    logic             last_of_run;
  } result_t;

  // up to two results of one item
  typedef struct packed {
    logic    v1;
    result_t r1;
    logic    v2;
    result_t r2;
  } res_pair_t;

  // line buffer write port; data is {row r-1, row r}
  typedef struct packed {
    logic              en;
    logic [COL_W-1:0]  addr;
    logic [LINE_W-1:0] data;
  } lb_wr_t;

endpackage

@@ sv/bf3_pix_if.sv @@
// ----------------------------------------------------------------------------
// bf3_pix_if
// Pixel input channel: valid/ready handshake with pixel and flush flag.
// ----------------------------------------------------------------------------
interface bf3_pix_if;
  logic                     valid;
  logic                     ready;
  logic [bf3_pkg::PIX_W-1:0] pixel;
  logic                     flush;

  modport source (output valid, output pixel, output flush, input ready);
  modport sink   (input valid, input pixel, input flush, output ready);
endinterface

@@ sv/bf3_sum_if.sv @@
// ----------------------------------------------------------------------------
// bf3_sum_if
// Result channel: valid/ready handshake with the neighbourhood sum and tags.
// ----------------------------------------------------------------------------
interface bf3_sum_if;
  logic                     valid;
  logic                     ready;
  logic [bf3_pkg::SUM_W-1:0] box_sum;
  logic [bf3_pkg::COL_W-1:0] out_column;
  logic                     end_of_row;
  logic                     end_of_frame;
  logic                     last_of_run;

  modport source (output valid, output box_sum, output out_column, output end_of_row,
                  output end_of_frame, output last_of_run, input ready);
  modport sink   (input valid, input box_sum, input out_column, input end_of_row,
                  input end_of_frame, input last_of_run, output ready);
endinterface

@@ sv/box_filter_3x3_stream.sv @@
// ----------------------------------------------------------------------------
// box_filter_3x3_stream
// 3x3 all-ones box filter over a raster pixel stream, one row and one column
// of latency, zero outside the frame.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake      | word
//  ----------+-----+----------------+-------------------------------------------
//  pixels    | in  | valid / ready  | pixel[7:0], flush
//  sums      | out | valid / ready  | box_sum[11:0], out_column[9:0],
//            |     |                | end_of_row, end_of_frame, last_of_run
//  cfg       | in  | cfg_we         | cfg_data[10:0] = frame_width
//
// One word per clock while the output pair has room; results go through the input
// register and slot 0 of the output pair. The last word of a row may give two
// results, the second held in slot 1 until the first is taken.
// Line buffer is a single-port-write, registered-read memory, no clearing pass.
// rst is synchronous; sums stall back into pixels through the output pair.
// ----------------------------------------------------------------------------
module box_filter_3x3_stream (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bf3_pkg::WID_W-1:0]  cfg_data,
  bf3_pix_if.sink                    pixels,
  bf3_sum_if.source                  sums
);

  logic [bf3_pkg::WID_W-1:0]  frame_width;
  logic [bf3_pkg::WID_W-1:0]  width_eff;
  logic [bf3_pkg::COL_W-1:0]  column_count;
  logic [bf3_pkg::COL_W-1:0]  column_count_next;
  bf3_pkg::phase_t            row_phase;
  bf3_pkg::phase_t            row_phase_next;
  bf3_pkg::item_t             item;
  logic                       item_v;
  logic                       in_acc;
  logic                       a_fire;
  logic                       room;
  logic                       eor;
  logic [bf3_pkg::LINE_W-1:0] line_q;
  bf3_pkg::res_pair_t         res;
  bf3_pkg::lb_wr_t            wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= bf3_pkg::WIDTH_RESET;
    end else if (cfg_we) begin
      frame_width <= cfg_data;
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      width_eff = bf3_pkg::WID_W'(1);
    end else if (frame_width > bf3_pkg::WIDTH_MAX) begin
      width_eff = bf3_pkg::WIDTH_MAX;
    end else begin
      width_eff = frame_width;
    end
  end

  assign eor    = ({1'b0, column_count} >= (width_eff - bf3_pkg::WID_W'(1)));
  assign a_fire = item_v && (!(res.v1 || res.v2) || room);
  assign pixels.ready = !item_v || a_fire;
  assign in_acc = pixels.valid && pixels.ready;

  // row position
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_phase    <= bf3_pkg::PH_FIRST;
    end else if (in_acc) begin
      column_count <= column_count_next;
      row_phase    <= row_phase_next;
    end
  end

  always_comb begin
    column_count_next = eor ? '0 : column_count + bf3_pkg::COL_W'(1);
    row_phase_next    = row_phase;
    if (eor) begin
      case (row_phase)
        bf3_pkg::PH_FIRST: begin
          if (!pixels.flush) row_phase_next = bf3_pkg::PH_SECOND;
        end
        bf3_pkg::PH_SECOND: begin
          row_phase_next = pixels.flush ? bf3_pkg::PH_FIRST : bf3_pkg::PH_LATER;
        end
        bf3_pkg::PH_LATER: begin
          if (pixels.flush) row_phase_next = bf3_pkg::PH_FIRST;
        end
        default: row_phase_next = bf3_pkg::PH_FIRST;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
    end else if (in_acc) begin
      item_v <= 1'b1;
    end else if (a_fire) begin
      item_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item.pix   <= pixels.flush ? '0 : pixels.pixel;
      item.flush <= pixels.flush;
      item.col   <= column_count;
      item.eor   <= eor;
      item.phase <= row_phase;
    end
  end

  bf3_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (column_count),
    .wr      (wr),
    .rd_data (line_q)
  );

  bf3_window u_window (
    .clk    (clk),
    .rst    (rst),
    .fire   (a_fire),
    .item   (item),
    .line_q (line_q),
    .res    (res),
    .wr     (wr)
  );

  bf3_out_queue u_out_queue (
    .clk  (clk),
    .rst  (rst),
    .push (a_fire),
    .res  (res),
    .room (room),
    .sums (sums)
  );

endmodule

@@ sv/bf3_line_buf.sv @@
// ----------------------------------------------------------------------------
// bf3_line_buf
// Two previous rows held side by side in one memory, registered read,
// with a bypass for a write to the address being read in the same cycle.
// ----------------------------------------------------------------------------
module bf3_line_buf (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [bf3_pkg::COL_W-1:0]         rd_addr,
  input  bf3_pkg::lb_wr_t                   wr,
  output logic [bf3_pkg::LINE_W-1:0]        rd_data
);

  logic [bf3_pkg::LINE_W-1:0] mem [bf3_pkg::MAX_WIDTH];
  logic [bf3_pkg::LINE_W-1:0] q;
  logic [bf3_pkg::LINE_W-1:0] fwd_data;
  logic                       fwd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  // width of one: consecutive items hit the same entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_hit  <= wr.en && (wr.addr == rd_addr);
      fwd_data <= wr.data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : q;

endmodule

@@ sv/bf3_window.sv @@
// ----------------------------------------------------------------------------
// bf3_window
// Two-column window registers and the column sums giving up to two results
// per item; also forms the line buffer write for the item.
// ----------------------------------------------------------------------------
module bf3_window (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  bf3_pkg::item_t             item,
  input  logic [bf3_pkg::LINE_W-1:0] line_q,
  output bf3_pkg::res_pair_t         res,
  output bf3_pkg::lb_wr_t            wr
);

  logic [bf3_pkg::PIX_W-1:0]  win1 [3];  // column c-1
  logic [bf3_pkg::PIX_W-1:0]  win2 [3];  // column c-2
  logic [bf3_pkg::PIX_W-1:0]  cur [3];
  logic [bf3_pkg::PIX_W-1:0]  prev;
  logic [bf3_pkg::PIX_W-1:0]  prev2;
  logic [bf3_pkg::CSUM_W-1:0] s_new;
  logic [bf3_pkg::CSUM_W-1:0] s_c1;
  logic [bf3_pkg::CSUM_W-1:0] s_c2;
  logic                       col0;
  logic                       live;

  assign prev2 = line_q[bf3_pkg::LINE_W-1:bf3_pkg::PIX_W];
  assign prev  = line_q[bf3_pkg::PIX_W-1:0];
  assign col0  = (item.col == '0);
  assign live  = (item.phase != bf3_pkg::PH_FIRST);

  assign cur[0] = (item.phase == bf3_pkg::PH_LATER) ? prev2 : '0;
  assign cur[1] = live ? prev : '0;
  assign cur[2] = item.pix;

  assign s_new = bf3_pkg::CSUM_W'(cur[0]) + bf3_pkg::CSUM_W'(cur[1])
               + bf3_pkg::CSUM_W'(cur[2]);
  assign s_c1  = col0 ? '0 : bf3_pkg::CSUM_W'(win1[0]) + bf3_pkg::CSUM_W'(win1[1])
                           + bf3_pkg::CSUM_W'(win1[2]);
  assign s_c2  = col0 ? '0 : bf3_pkg::CSUM_W'(win2[0]) + bf3_pkg::CSUM_W'(win2[1])
                           + bf3_pkg::CSUM_W'(win2[2]);

  always_comb begin
    res.v1              = live && !col0;
    res.r1.box_sum      = bf3_pkg::SUM_W'(s_c2) + bf3_pkg::SUM_W'(s_c1)
                        + bf3_pkg::SUM_W'(s_new);
    res.r1.out_column   = item.col - bf3_pkg::COL_W'(1);
    res.r1.end_of_row   = 1'b0;
    res.r1.end_of_frame = 1'b0;
    res.r1.last_of_run  = !item.eor;
    res.v2              = live && item.eor;
    res.r2.box_sum      = bf3_pkg::SUM_W'(s_c1) + bf3_pkg::SUM_W'(s_new);
    res.r2.out_column   = item.col;
    res.r2.end_of_row   = 1'b1;
    res.r2.end_of_frame = item.flush;
    res.r2.last_of_run  = 1'b1;
  end

  assign wr.en   = fire;
  assign wr.addr = item.col;
  assign wr.data = {prev, item.pix};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win1[i] <= '0;
        win2[i] <= '0;
      end
    end else if (fire) begin
      for (int i = 0; i < 3; i++) begin
        win1[i] <= cur[i];
        win2[i] <= col0 ? '0 : win1[i];
      end
    end
  end

endmodule

@@ sv/bf3_out_queue.sv @@
// ----------------------------------------------------------------------------
// bf3_out_queue
// Two-slot result register: slot 0 drives the port, slot 1 holds the
// end-of-row result that follows in the same item.
// ----------------------------------------------------------------------------
module bf3_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bf3_pkg::res_pair_t res,
  output logic               room,
  bf3_sum_if.source          sums
);

  bf3_pkg::result_t slot0;
  bf3_pkg::result_t slot1;
  logic             slot0_v;
  logic             slot1_v;
  logic             take;
  logic             push_any;

  assign take     = slot0_v && sums.ready;
  assign room     = !slot1_v && (!slot0_v || sums.ready);
  assign push_any = push && (res.v1 || res.v2);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot0_v <= 1'b0;
      slot1_v <= 1'b0;
    end else if (push_any) begin
      slot0_v <= 1'b1;
      slot1_v <= res.v1 && res.v2;
    end else if (take) begin
      slot0_v <= slot1_v;
      slot1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_any) begin
      slot0 <= res.v1 ? res.r1 : res.r2;
      slot1 <= res.r2;
    end else if (take) begin
      slot0 <= slot1;
    end
  end

  assign sums.valid        = slot0_v;
  assign sums.box_sum      = slot0.box_sum;
  assign sums.out_column   = slot0.out_column;
  assign sums.end_of_row   = slot0.end_of_row;
  assign sums.end_of_frame = slot0.end_of_frame;
  assign sums.last_of_run  = slot0.last_of_run;

endmodule

@@ sv/bf3_checker.sv @@
// ----------------------------------------------------------------------------
// bf3_checker
// Port-level checks of the box filter stream, bound to the top level.
// ----------------------------------------------------------------------------
module bf3_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic end_of_row,
  input logic end_of_frame,
  input logic last_of_run
);

  // a frame only closes on a row end
  a_eof_on_eor: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> end_of_row)
    else $error("end_of_frame without end_of_row");

  // every row end closes the run of its word
  a_eor_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_row |-> last_of_run)
    else $error("end_of_row without last_of_run");

  // a run that is not finished continues at once with the row-end result
  a_run_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid && end_of_row)
    else $error("second result of a row end missing");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

endmodule

bind box_filter_3x3_stream bf3_checker u_bf3_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (sums.valid),
  .out_ready    (sums.ready),
  .end_of_row   (sums.end_of_row),
  .end_of_frame (sums.end_of_frame),
  .last_of_run  (sums.last_of_run)
);

@@ tb/sv/box_sum_checker.sv @@
// ----------------------------------------------------------------------------
// box_sum_checker
// Watches the pixel and sum channels of the 3x3 box filter. It keeps its own
// line buffers, window and row state, predicts the sums caused by every
// accepted pixel word and compares each accepted sum word field by field.
// ----------------------------------------------------------------------------
module box_sum_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bf3_pkg::WID_W-1:0] cfg_data,
  bf3_pix_if                        pixels,
  bf3_sum_if                        sums,
  output int                        errors,
  output int                        sums_pending,
  output int                        sums_checked,
  output int                        frames_closed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 40;

  logic [bf3_pkg::WID_W-1:0]      frame_width;
  logic [bf3_pkg::PIX_W-1:0]      row_above  [bf3_pkg::MAX_WIDTH];  // row r-1
  logic [bf3_pkg::PIX_W-1:0]      row_two_up [bf3_pkg::MAX_WIDTH];  // row r-2
  logic [2:0][bf3_pkg::PIX_W-1:0] win_c1;                           // column c-1
  logic [2:0][bf3_pkg::PIX_W-1:0] win_c2;                           // column c-2
  int unsigned                    next_col;
  bf3_pkg::phase_t                row_state;
  bf3_pkg::result_t               sums_q [$];

  function automatic logic [bf3_pkg::SUM_W-1:0] col_total(
    input logic [2:0][bf3_pkg::PIX_W-1:0] v);
    return bf3_pkg::SUM_W'(v[0]) + bf3_pkg::SUM_W'(v[1]) + bf3_pkg::SUM_W'(v[2]);
  endfunction

  task automatic report(input string what, input int got_v, input int want_v);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("[%0t] sum word %0d: %s got %0d want %0d", $time, sums_checked, what,
               got_v, want_v);
  endtask

  task automatic predict_sums(input logic [bf3_pkg::PIX_W-1:0] pix_in,
                              input logic flush_in);
    int unsigned                    w;
    int unsigned                    c;
    logic                           eor;
    logic [2:0][bf3_pkg::PIX_W-1:0] cur;
    logic [bf3_pkg::SUM_W-1:0]      s_new;
    logic [bf3_pkg::SUM_W-1:0]      s_c1;
    logic [bf3_pkg::SUM_W-1:0]      s_c2;
    bf3_pkg::result_t               r;
    w = int'(frame_width);
    if (w == 0) w = 1;
    if (w > bf3_pkg::MAX_WIDTH) w = bf3_pkg::MAX_WIDTH;
    c = next_col;
    eor = (c >= w - 1);
    // a flush word stands for a zero pixel
    cur[0] = flush_in ? '0 : pix_in;
    cur[1] = (row_state != bf3_pkg::PH_FIRST) ? row_above[c] : '0;
    cur[2] = (row_state == bf3_pkg::PH_LATER) ? row_two_up[c] : '0;
    if (c == 0) begin
      win_c1 = '0;
      win_c2 = '0;
    end
    if (row_state != bf3_pkg::PH_FIRST) begin
      s_new = col_total(cur);
      s_c1  = col_total(win_c1);
      s_c2  = col_total(win_c2);
      if (c >= 1) begin
        r.box_sum      = s_c2 + s_c1 + s_new;
        r.out_column   = bf3_pkg::COL_W'(c - 1);
        r.end_of_row   = 1'b0;
        r.end_of_frame = 1'b0;
        r.last_of_run  = !eor;
        sums_q.push_back(r);
      end
      if (eor) begin
        r.box_sum      = s_c1 + s_new;
        r.out_column   = bf3_pkg::COL_W'(c);
        r.end_of_row   = 1'b1;
        r.end_of_frame = flush_in;
        r.last_of_run  = 1'b1;
        sums_q.push_back(r);
      end
    end
    win_c2 = win_c1;
    win_c1 = cur;
    row_two_up[c] = row_above[c];
    row_above[c]  = cur[0];
    if (eor) begin
      next_col = 0;
      if (flush_in && row_state != bf3_pkg::PH_FIRST) row_state = bf3_pkg::PH_FIRST;
      else if (!flush_in && row_state == bf3_pkg::PH_FIRST) row_state = bf3_pkg::PH_SECOND;
      else if (!flush_in) row_state = bf3_pkg::PH_LATER;
    end else begin
      next_col = c + 1;
    end
  endtask

  always @(posedge clk) begin
    bf3_pkg::result_t got;
    bf3_pkg::result_t want;
    if (rst) begin
      frame_width = bf3_pkg::WIDTH_RESET;
      for (int i = 0; i < bf3_pkg::MAX_WIDTH; i++) begin
        row_above[i]  = '0;
        row_two_up[i] = '0;
      end
      win_c1        = '0;
      win_c2        = '0;
      next_col      = 0;
      row_state     = bf3_pkg::PH_FIRST;
      errors        = 0;
      sums_checked  = 0;
      frames_closed = 0;
      sums_q.delete();
    end else begin
      // sums leave through registers after their pixel word, so check first
      if (sums.valid && sums.ready) begin
        got = '{sums.box_sum, sums.out_column, sums.end_of_row, sums.end_of_frame,
                sums.last_of_run};
        sums_checked++;
        if (got.end_of_frame === 1'b1) frames_closed++;
        if (sums_q.size() == 0) begin
          report("unexpected word, box_sum", int'(got.box_sum), -1);
        end else begin
          want = sums_q.pop_front();
          if (got.box_sum !== want.box_sum)
            report("box_sum", int'(got.box_sum), int'(want.box_sum));
          if (got.out_column !== want.out_column)
            report("out_column", int'(got.out_column), int'(want.out_column));
          if (got.end_of_row !== want.end_of_row)
            report("end_of_row", int'(got.end_of_row), int'(want.end_of_row));
          if (got.end_of_frame !== want.end_of_frame)
            report("end_of_frame", int'(got.end_of_frame), int'(want.end_of_frame));
          if (got.last_of_run !== want.last_of_run)
            report("last_of_run", int'(got.last_of_run), int'(want.last_of_run));
        end
      end
      if (cfg_we) frame_width = cfg_data;
      if (pixels.valid && pixels.ready) predict_sums(pixels.pixel, pixels.flush);
    end
    sums_pending <= sums_q.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the 3x3 box filter stream: a short directed run
// over the border and width corner cases, then random frames and noise with
// random gaps on both channels, checked by box_sum_checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS   = 300;
  localparam int SETTLE_CYCLES  = 4;     // latency of the block plus margin
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int NARROW_MAX     = 64;

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      cfg_we   = 1'b0;
  logic [bf3_pkg::WID_W-1:0] cfg_data = '0;

  bf3_pix_if pix_ch ();
  bf3_sum_if sum_ch ();

  int errors;
  int sums_pending;
  int sums_checked;
  int frames_closed;

  // what the stimulus knows of the row it is in
  int cur_width   = bf3_pkg::MAX_WIDTH;
  int col_pos     = 0;
  bit frame_open  = 1'b0;
  bit gap_free    = 1'b0;
  int words_sent  = 0;
  int small_words = 0;
  int cfg_writes  = 0;
  int widest      = 0;

  int rdy_left    = 0;
  bit rdy_level   = 1'b0;
  int idle_cycles = 0;

  box_filter_3x3_stream i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .pixels   (pix_ch),
    .sums     (sum_ch)
  );

  box_sum_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .pixels        (pix_ch),
    .sums          (sum_ch),
    .errors        (errors),
    .sums_pending  (sums_pending),
    .sums_checked  (sums_checked),
    .frames_closed (frames_closed)
  );

  always #1 clk = ~clk;

  // sink side: runs of ready and stall, now and then a long free run
  always @(posedge clk) begin
    int roll;
    if (rdy_left == 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        rdy_level = 1'b1;
        rdy_left  = $urandom_range(1, 12);
      end else if (roll < 85) begin
        rdy_level = 1'b0;
        rdy_left  = $urandom_range(1, 3);
      end else if (roll < 93) begin
        rdy_level = 1'b1;
        rdy_left  = $urandom_range(60, 200);
      end else begin
        rdy_level = 1'b0;
        rdy_left  = $urandom_range(10, 40);
      end
    end
    rdy_left--;
    sum_ch.ready <= rdy_level;
  end

  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (sum_ch.valid && sum_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a word moving", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    if (gap_free) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [bf3_pkg::PIX_W-1:0] rand_pixel();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return bf3_pkg::PIX_W'($urandom);
  endfunction

  task automatic push_word(input logic [bf3_pkg::PIX_W-1:0] pix, input logic flsh);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= pix;
    pix_ch.flush <= flsh;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    words_sent++;
    if (cur_width <= NARROW_MAX) small_words++;
    if (col_pos >= cur_width - 1) begin
      col_pos    = 0;
      frame_open = !flsh;
    end else begin
      col_pos++;
    end
  endtask

  // hold off the sender until every predicted sum has left the block
  task automatic settle_block();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (sums_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [bf3_pkg::WID_W-1:0] raw);
    settle_block();
    cfg_we   <= 1'b1;
    cfg_data <= raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (raw == 0) cur_width = 1;
    else if (raw > bf3_pkg::WIDTH_MAX) cur_width = bf3_pkg::MAX_WIDTH;
    else cur_width = int'(raw);
    if (cur_width > widest) widest = cur_width;
    cfg_writes++;
  endtask

  // image rows of random content, closed by one row of flush words
  task automatic send_frame();
    int rows;
    rows = (cur_width > NARROW_MAX) ? 1 : $urandom_range(1, 4);
    while (col_pos != 0) push_word(rand_pixel(), 1'b0);
    repeat (rows) repeat (cur_width) push_word(rand_pixel(), 1'b0);
    repeat (cur_width) push_word(bf3_pkg::PIX_W'($urandom), 1'b1);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 2 * cur_width + 3);
    repeat (n) push_word(rand_pixel(), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int                        roll;
    logic [bf3_pkg::WID_W-1:0] raw;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    pix_ch.flush = 1'b0;
    sum_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full-scale frame: centre sum of nine saturated pixels
    write_width(bf3_pkg::WID_W'(3));
    repeat (9) push_word('1, 1'b0);
    repeat (3) push_word('0, 1'b1);

    // width zero acts as one; a flush in the first row closes nothing
    write_width('0);
    push_word('0, 1'b0);
    push_word('1, 1'b1);
    push_word(8'hC3, 1'b1);

    // width shrunk in the middle of a row ends that row at once
    write_width(bf3_pkg::WID_W'(3));
    repeat (3) push_word(rand_pixel(), 1'b0);
    push_word(8'h80, 1'b0);
    push_word(8'h01, 1'b0);
    write_width(bf3_pkg::WID_W'(2));
    push_word(8'h7E, 1'b0);
    // pixel and flush mixed in the closing row
    push_word(8'hA5, 1'b0);
    push_word(8'h5A, 1'b1);

    // widest row, width beyond the maximum; the frame then goes on narrow
    write_width('1);
    repeat (cur_width) push_word(rand_pixel(), 1'b0);
    write_width(bf3_pkg::WID_W'(3));
    send_frame();

    while (small_words < RANDOM_WORDS) begin
      gap_free = ($urandom_range(0, 3) == 0);
      if (cur_width > NARROW_MAX || $urandom_range(0, 99) < 30) begin
        // the width may only grow between frames
        if (frame_open) begin
          raw = bf3_pkg::WID_W'($urandom_range(0, cur_width));
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 6) raw = '0;
          else if (roll < 80) raw = bf3_pkg::WID_W'($urandom_range(1, 8));
          else raw = bf3_pkg::WID_W'($urandom_range(9, 40));
        end
        write_width(raw);
      end else if ($urandom_range(0, 19) == 0) begin
        settle_block();
      end
      if (cur_width > NARROW_MAX || $urandom_range(0, 99) < 75) send_frame();
      else send_noise();
    end

    gap_free = 1'b0;
    settle_block();
    $display("Covered %0d pixel words over %0d width settings, widest row %0d pixels",
             words_sent, cfg_writes, widest);
    $display("Checked %0d sum words, %0d frames closed, %0d mismatches",
             sums_checked, frames_closed, errors);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
sv/bf3_pkg.sv
sv/bf3_pix_if.sv
sv/bf3_sum_if.sv
sv/bf3_line_buf.sv
sv/bf3_window.sv
sv/bf3_out_queue.sv
sv/box_filter_3x3_stream.sv
sv/bf3_checker.sv
tb/sv/box_sum_checker.sv
tb/sv/testbench.sv
